### rtl/ptad_pkg.sv
// ----------------------------------------------------------------------------
// ptad_pkg
// Shared types, register indexes and constants of the pixel to ASCII
// downscaler.
// ----------------------------------------------------------------------------
package ptad_pkg;

    localparam int CFG_W = 13;

    localparam logic [2:0] REG_SRC_WIDTH  = 3'd0;
    localparam logic [2:0] REG_SRC_HEIGHT = 3'd1;
    localparam logic [2:0] REG_DST_WIDTH  = 3'd2;
    localparam logic [2:0] REG_DST_HEIGHT = 3'd3;
    localparam logic [2:0] REG_GRAY_INPUT = 3'd4;

    localparam logic [CFG_W-1:0] SRC_WIDTH_RST  = 13'd640;
    localparam logic [CFG_W-1:0] SRC_HEIGHT_RST = 13'd480;
    localparam logic [CFG_W-1:0] DST_WIDTH_RST  = 13'd80;
    localparam logic [CFG_W-1:0] DST_HEIGHT_RST = 13'd30;

    localparam logic [6:0] NEWLINE_CODE = 7'd10;
    localparam int         RAMP_SIZE    = 10;

    localparam logic [17:0] WEIGHT_RED   = 18'd299;
    localparam logic [17:0] WEIGHT_GREEN = 18'd587;
    localparam logic [17:0] WEIGHT_BLUE  = 18'd114;

    // floor(x / 1000) == (x * GRAY_RECIP) >> GRAY_SHIFT for x <= 255000
    localparam logic [36:0] GRAY_RECIP = 37'd268436;
    localparam int          GRAY_SHIFT = 28;

    typedef struct packed {
        logic [CFG_W-1:0] src_width;
        logic [CFG_W-1:0] src_height;
        logic [CFG_W-1:0] dst_width;
        logic [CFG_W-1:0] dst_height;
        logic             gray_input;
    } cfg_t;

    typedef struct packed {
        logic       mono;
        logic       newline;
        logic       eof;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pix_t;

    typedef struct packed {
        logic       newline;
        logic       eof;
        logic [6:0] code;
    } char_t;

    function automatic logic [6:0] ramp_char(input logic [3:0] idx);
        logic [6:0] c;
        case (idx)
            4'd0:    c = 7'h20;
            4'd1:    c = 7'h2E;
            4'd2:    c = 7'h3A;
            4'd3:    c = 7'h2D;
            4'd4:    c = 7'h3D;
            4'd5:    c = 7'h2B;
            4'd6:    c = 7'h2A;
            4'd7:    c = 7'h23;
            4'd8:    c = 7'h25;
            default: c = 7'h40;
        endcase
        return c;
    endfunction

endpackage

### rtl/ptad_cfg.sv
// ----------------------------------------------------------------------------
// ptad_cfg
// Configuration registers, clamping of the dimensions and frame restart on
// a dimension write.
// ----------------------------------------------------------------------------
module ptad_cfg #(
    parameter int MAX_DIM = 4096
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [2:0]               cfg_index,
    input  logic [ptad_pkg::CFG_W-1:0] cfg_data,
    output ptad_pkg::cfg_t           cfg_eff,
    output logic                     restart
);

    localparam int DIM_CAP = (MAX_DIM < 8191) ? MAX_DIM : 8191;
    localparam logic [ptad_pkg::CFG_W-1:0] CAP = ptad_pkg::CFG_W'(DIM_CAP);

    logic [ptad_pkg::CFG_W-1:0] src_width_reg, src_height_reg;
    logic [ptad_pkg::CFG_W-1:0] dst_width_reg, dst_height_reg;
    logic                       gray_input_reg;
    logic                       wr;
    logic [ptad_pkg::CFG_W-1:0] sw, sh, dw, dh;

    function automatic logic [ptad_pkg::CFG_W-1:0] clamp_dim(
        input logic [ptad_pkg::CFG_W-1:0] v
    );
        logic [ptad_pkg::CFG_W-1:0] r;
        if (v == '0) begin
            r = ptad_pkg::CFG_W'(1);
        end else if (v > CAP) begin
            r = CAP;
        end else begin
            r = v;
        end
        return r;
    endfunction

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid & cfg_ready;
    assign restart   = wr & ((cfg_index == ptad_pkg::REG_SRC_WIDTH)
                          || (cfg_index == ptad_pkg::REG_SRC_HEIGHT)
                          || (cfg_index == ptad_pkg::REG_DST_WIDTH)
                          || (cfg_index == ptad_pkg::REG_DST_HEIGHT));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_width_reg  <= ptad_pkg::SRC_WIDTH_RST;
            src_height_reg <= ptad_pkg::SRC_HEIGHT_RST;
            dst_width_reg  <= ptad_pkg::DST_WIDTH_RST;
            dst_height_reg <= ptad_pkg::DST_HEIGHT_RST;
            gray_input_reg <= 1'b0;
        end else if (wr) begin
            case (cfg_index)
                ptad_pkg::REG_SRC_WIDTH:  src_width_reg  <= cfg_data;
                ptad_pkg::REG_SRC_HEIGHT: src_height_reg <= cfg_data;
                ptad_pkg::REG_DST_WIDTH:  dst_width_reg  <= cfg_data;
                ptad_pkg::REG_DST_HEIGHT: dst_height_reg <= cfg_data;
                ptad_pkg::REG_GRAY_INPUT: gray_input_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        sw = clamp_dim(src_width_reg);
        sh = clamp_dim(src_height_reg);
        dw = clamp_dim(dst_width_reg);
        dh = clamp_dim(dst_height_reg);
        if (dw > sw) dw = sw;
        if (dh > sh) dh = sh;
        cfg_eff.src_width  = sw;
        cfg_eff.src_height = sh;
        cfg_eff.dst_width  = dw;
        cfg_eff.dst_height = dh;
        cfg_eff.gray_input = gray_input_reg;
    end

endmodule

### rtl/ptad_sel.sv
// ----------------------------------------------------------------------------
// ptad_sel
// Raster counters and accumulators that pick the nearest-neighbor pixel of
// each output cell; the picked pixel lands in the input register.
// ----------------------------------------------------------------------------
module ptad_sel #(
    parameter int MAX_DIM = 4096
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  ptad_pkg::cfg_t cfg_eff,
    input  logic           restart,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [7:0]     in_red,
    input  logic [7:0]     in_green,
    input  logic [7:0]     in_blue,
    output logic           out_valid,
    input  logic           out_ready,
    output ptad_pkg::pix_t out_data
);

    localparam int DIM_CAP = (MAX_DIM < 8191) ? MAX_DIM : 8191;
    localparam int DW      = $clog2(DIM_CAP + 1);
    localparam int AW      = 2 * DW;

    logic [DW-1:0] sc_reg, sc_next, sr_reg, sr_next;
    logic [DW-1:0] oc_reg, oc_next, or_reg, or_next;
    logic [AW-1:0] ct_reg, ct_next, cs_reg, cs_next;
    logic [AW-1:0] rt_reg, rt_next, rs_reg, rs_next;
    logic          valid_reg, valid_next;
    ptad_pkg::pix_t data_reg, data_next;

    logic [DW-1:0] w_src, h_src, w_dst, h_dst;
    logic          accept, row_sel, col_sel, hit, row_end, last_row;

    assign w_src = DW'(cfg_eff.src_width);
    assign h_src = DW'(cfg_eff.src_height);
    assign w_dst = DW'(cfg_eff.dst_width);
    assign h_dst = DW'(cfg_eff.dst_height);

    assign in_ready  = (!valid_reg || out_ready) && !restart;
    assign accept    = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    assign row_sel  = (or_reg < h_dst)
                   && ({1'b0, rt_reg} < ({1'b0, rs_reg} + (AW+1)'(h_dst)));
    assign col_sel  = (oc_reg < w_dst)
                   && ({1'b0, ct_reg} < ({1'b0, cs_reg} + (AW+1)'(w_dst)));
    assign hit      = row_sel && col_sel;
    assign row_end  = ((DW+1)'(sc_reg) + (DW+1)'(1)) >= (DW+1)'(w_src);
    assign last_row = ((DW+1)'(sr_reg) + (DW+1)'(1)) >= (DW+1)'(h_src);

    always_comb begin
        sc_next = sc_reg;
        sr_next = sr_reg;
        oc_next = oc_reg;
        or_next = or_reg;
        ct_next = ct_reg;
        cs_next = cs_reg;
        rt_next = rt_reg;
        rs_next = rs_reg;
        valid_next = valid_reg;
        data_next  = data_reg;
        if (restart) begin
            sc_next = '0; sr_next = '0; oc_next = '0; or_next = '0;
            ct_next = '0; cs_next = '0; rt_next = '0; rs_next = '0;
            if (out_ready) valid_next = 1'b0;
        end else if (accept) begin
            valid_next        = hit;
            data_next.red     = in_red;
            data_next.green   = in_green;
            data_next.blue    = in_blue;
            data_next.mono    = cfg_eff.gray_input;
            data_next.newline = ((DW+1)'(oc_reg) + (DW+1)'(1)) >= (DW+1)'(w_dst);
            data_next.eof     = ((DW+1)'(or_reg) + (DW+1)'(1)) >= (DW+1)'(h_dst);
            if (row_end) begin
                sc_next = '0;
                oc_next = '0;
                ct_next = '0;
                cs_next = '0;
                if (last_row) begin
                    sr_next = '0; or_next = '0; rt_next = '0; rs_next = '0;
                end else begin
                    if (row_sel) begin
                        or_next = or_reg + DW'(1);
                        rt_next = rt_reg + AW'(h_src);
                    end
                    sr_next = sr_reg + DW'(1);
                    rs_next = rs_reg + AW'(h_dst);
                end
            end else begin
                sc_next = sc_reg + DW'(1);
                cs_next = cs_reg + AW'(w_dst);
                if (hit) begin
                    oc_next = oc_reg + DW'(1);
                    ct_next = ct_reg + AW'(w_src);
                end
            end
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sc_reg <= '0; sr_reg <= '0; oc_reg <= '0; or_reg <= '0;
            ct_reg <= '0; cs_reg <= '0; rt_reg <= '0; rs_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            sc_reg <= sc_next; sr_reg <= sr_next;
            oc_reg <= oc_next; or_reg <= or_next;
            ct_reg <= ct_next; cs_reg <= cs_next;
            rt_reg <= rt_next; rs_reg <= rs_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    a_col_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        sc_reg < w_src) else $error("source column beyond source width");

    a_ocol_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        oc_reg <= w_dst) else $error("output column beyond output width");

    a_orow_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        or_reg <= h_dst) else $error("output row beyond output height");

endmodule

### rtl/ptad_gray.sv
// ----------------------------------------------------------------------------
// ptad_gray
// Three-stage luma and ramp pipeline: weighted sum, divide by 1000 through
// a reciprocal multiply, ramp character lookup. Mono input uses red as gray.
// ----------------------------------------------------------------------------
module ptad_gray #(
    parameter int RAMP_LEVELS = 10
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  ptad_pkg::pix_t  in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output ptad_pkg::char_t out_data
);

    localparam int PW  = 8 + $clog2(RAMP_LEVELS + 1);
    localparam int TOP = (RAMP_LEVELS < ptad_pkg::RAMP_SIZE) ? RAMP_LEVELS
                                                            : ptad_pkg::RAMP_SIZE;

    logic        v2_reg, v3_reg, v4_reg;
    logic        adv2, adv3, adv4;
    logic [17:0] sum2_reg;
    logic        mono2_reg, nl2_reg, eof2_reg;
    logic [7:0]  gray3_reg;
    logic        nl3_reg, eof3_reg;
    ptad_pkg::char_t out4_reg;

    logic [17:0]   sum_next;
    logic [36:0]   quot_prod;
    logic [7:0]    gray_next;
    logic [PW-1:0] lvl_prod;
    logic [PW-9:0] idx_raw;
    logic [3:0]    idx;

    assign adv4     = !v4_reg || out_ready;
    assign adv3     = !v3_reg || adv4;
    assign adv2     = !v2_reg || adv3;
    assign in_ready = adv2;

    assign out_valid = v4_reg;
    assign out_data  = out4_reg;

    always_comb begin
        sum_next  = 18'(in_data.red) * ptad_pkg::WEIGHT_RED
                  + 18'(in_data.green) * ptad_pkg::WEIGHT_GREEN
                  + 18'(in_data.blue) * ptad_pkg::WEIGHT_BLUE;
        if (in_data.mono) sum_next = 18'(in_data.red);
    end

    assign quot_prod = 37'(sum2_reg) * ptad_pkg::GRAY_RECIP;
    assign gray_next = mono2_reg ? sum2_reg[7:0]
                                 : quot_prod[ptad_pkg::GRAY_SHIFT +: 8];

    assign lvl_prod = PW'(gray3_reg) * PW'(RAMP_LEVELS);
    assign idx_raw  = lvl_prod[PW-1:8];
    assign idx      = (int'(idx_raw) >= TOP) ? 4'(TOP - 1) : 4'(idx_raw);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (adv2) v2_reg <= in_valid;
            if (adv3) v3_reg <= v2_reg;
            if (adv4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv2) begin
            sum2_reg  <= sum_next;
            mono2_reg <= in_data.mono;
            nl2_reg   <= in_data.newline;
            eof2_reg  <= in_data.eof;
        end
        if (adv3) begin
            gray3_reg <= gray_next;
            nl3_reg   <= nl2_reg;
            eof3_reg  <= eof2_reg;
        end
        if (adv4) begin
            out4_reg.code    <= ptad_pkg::ramp_char(idx);
            out4_reg.newline <= nl3_reg;
            out4_reg.eof     <= eof3_reg;
        end
    end

endmodule

### rtl/ptad_out.sv
// ----------------------------------------------------------------------------
// ptad_out
// Output register; sends the ramp character and, at a row end, a newline
// beat right after it.
// ----------------------------------------------------------------------------
module ptad_out (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  ptad_pkg::char_t in_data,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [7:0]      m_tdata,   // [6:0] char_code, [7] zero
    output logic            m_tuser,   // [0] last_of_item
    output logic            m_tlast    // end_of_frame
);

    logic       valid_reg, valid_next;
    logic       nl_pend_reg, nl_pend_next;
    logic       eof_pend_reg, eof_pend_next;
    logic [6:0] code_reg, code_next;
    logic       last_reg, last_next;
    logic       eof_reg, eof_next;
    logic       take;

    assign take     = valid_reg && m_tready;
    assign in_ready = !valid_reg || (take && !nl_pend_reg);

    always_comb begin
        valid_next    = valid_reg;
        nl_pend_next  = nl_pend_reg;
        eof_pend_next = eof_pend_reg;
        code_next     = code_reg;
        last_next     = last_reg;
        eof_next      = eof_reg;
        if (in_valid && in_ready) begin
            valid_next    = 1'b1;
            code_next     = in_data.code;
            last_next     = !in_data.newline;
            eof_next      = 1'b0;
            nl_pend_next  = in_data.newline;
            eof_pend_next = in_data.eof;
        end else if (take && nl_pend_reg) begin
            code_next    = ptad_pkg::NEWLINE_CODE;
            last_next    = 1'b1;
            eof_next     = eof_pend_reg;
            nl_pend_next = 1'b0;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= 1'b0;
            nl_pend_reg <= 1'b0;
        end else begin
            valid_reg   <= valid_next;
            nl_pend_reg <= nl_pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        eof_pend_reg <= eof_pend_next;
        code_reg     <= code_next;
        last_reg     <= last_next;
        eof_reg      <= eof_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {1'b0, code_reg};
    assign m_tuser  = last_reg;
    assign m_tlast  = eof_reg;

    a_pend_needs_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        nl_pend_reg |-> valid_reg) else $error("newline pending without a beat");

    a_eof_is_newline: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && eof_reg) |-> (code_reg == ptad_pkg::NEWLINE_CODE && last_reg))
        else $error("end of frame on a non-newline beat");

    a_not_last_pends: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && !last_reg) |-> nl_pend_reg)
        else $error("character marked not last with no newline pending");

endmodule

### rtl/pixel_to_ascii_downscaler.sv
// ----------------------------------------------------------------------------
// pixel_to_ascii_downscaler
// Nearest-neighbor downscaler that turns a raster pixel stream into ASCII
// art characters.
//
// Pixels enter on the s_ stream in raster order, one beat per pixel. Each
// selected pixel yields one ramp character on the m_ stream; the pixel that
// closes an output row also yields a newline beat, with m_tlast set on the
// newline that ends the frame. Unselected pixels yield nothing.
// The cfg channel writes the dimension and mode registers; a dimension write
// restarts the frame. Write it only while the stream is idle.
// One pixel is taken every cycle unless back-pressure or a restart holds
// s_tready low. A pixel reaches the m_ side through the input register,
// three pipeline stages and the output register. A pixel with a newline
// holds the output register for a character beat and a newline beat.
// Reset returns the registers to 640x480 -> 80x30 RGB and clears all
// counters and the pipeline. When m_tready is low the pipeline fills and
// s_tready falls; nothing is dropped.
// ----------------------------------------------------------------------------
module pixel_to_ascii_downscaler #(
    parameter int MAX_DIM     = 4096,
    parameter int RAMP_LEVELS = 10
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [23:0]                s_tdata,  // [7:0] red, [15:8] green, [23:16] blue
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [7:0]                 m_tdata,  // [6:0] char_code, [7] zero
    output logic                       m_tuser,  // [0] last_of_item
    output logic                       m_tlast,  // end_of_frame
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [2:0]                 cfg_index,
    input  logic [ptad_pkg::CFG_W-1:0] cfg_data
);

    ptad_pkg::cfg_t  cfg_eff;
    logic            restart;
    logic            sel_valid, sel_ready;
    ptad_pkg::pix_t  sel_data;
    logic            chr_valid, chr_ready;
    ptad_pkg::char_t chr_data;

    ptad_cfg #(
        .MAX_DIM (MAX_DIM)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_eff   (cfg_eff),
        .restart   (restart)
    );

    ptad_sel #(
        .MAX_DIM (MAX_DIM)
    ) u_sel (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_eff   (cfg_eff),
        .restart   (restart),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_red    (s_tdata[7:0]),
        .in_green  (s_tdata[15:8]),
        .in_blue   (s_tdata[23:16]),
        .out_valid (sel_valid),
        .out_ready (sel_ready),
        .out_data  (sel_data)
    );

    ptad_gray #(
        .RAMP_LEVELS (RAMP_LEVELS)
    ) u_gray (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (sel_valid),
        .in_ready  (sel_ready),
        .in_data   (sel_data),
        .out_valid (chr_valid),
        .out_ready (chr_ready),
        .out_data  (chr_data)
    );

    ptad_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (chr_valid),
        .in_ready (chr_ready),
        .in_data  (chr_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
